// File: rtl/tsi_pkg.sv
// Package for the pump relay thermal safety interlock.
// Holds command, mode and alert codes, register indexes, reset values and shared structs.
// No dependencies.
package tsi_pkg;

  localparam int unsigned TempW    = 12;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned AlertW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  // 3.0 degree warning hysteresis in 1/16 degree units
  localparam logic signed [TempW:0] HystSixteenths = 13'sd48;

  localparam logic signed [TempW-1:0] CriticalReset = 12'sd960;
  localparam logic signed [TempW-1:0] WarningReset  = 12'sd800;
  localparam logic signed [TempW-1:0] ResumeReset   = 12'sd640;
  localparam logic [CountW-1:0]       CrashReset    = 8'd3;
  localparam logic [CountW-1:0]       CountMax      = 8'hFF;

  typedef enum logic [CmdW-1:0] {
    CmdBoot   = 3'd0,
    CmdCheck  = 3'd1,
    CmdArm    = 3'd2,
    CmdDisarm = 3'd3,
    CmdReset  = 3'd4
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    ModeNominal = 2'd0,
    ModeWarning = 2'd1,
    ModeLockout = 2'd2
  } mode_e;

  typedef enum logic [AlertW-1:0] {
    AlertNone     = 3'd0,
    AlertCritical = 3'd1,
    AlertWarning  = 3'd2,
    AlertResumed  = 3'd3,
    AlertReset    = 3'd4
  } alert_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCritical = 2'd0,
    RegWarning  = 2'd1,
    RegResume   = 2'd2,
    RegCrash    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [TempW-1:0] critical_level;
    logic signed [TempW-1:0] warning_level;
    logic signed [TempW-1:0] resume_level;
    logic [CountW-1:0]       crash_limit;
  } cfg_t;

  typedef struct packed {
    logic              relay_on;
    logic [ModeW-1:0]  safety_mode;
    logic              accepted;
    logic [AlertW-1:0] alert_code;
    logic              thermal_locked;
    logic              loop_guard;
    logic [CountW-1:0] boots_seen;
  } result_t;

endpackage

// File: rtl/tsi_cfg_regs.sv
// Configuration registers of the thermal safety interlock: levels and crash limit.
// Depends on tsi_pkg.
module tsi_cfg_regs import tsi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.critical_level <= CriticalReset;
      cfg_q.warning_level  <= WarningReset;
      cfg_q.resume_level   <= ResumeReset;
      cfg_q.crash_limit    <= CrashReset;
    end else if (wr_en_i) begin
      unique case (reg_idx_e'(wr_index_i))
        RegCritical: cfg_q.critical_level <= signed'(wr_data_i[TempW-1:0]);
        RegWarning:  cfg_q.warning_level  <= signed'(wr_data_i[TempW-1:0]);
        RegResume:   cfg_q.resume_level   <= signed'(wr_data_i[TempW-1:0]);
        RegCrash:    cfg_q.crash_limit    <= wr_data_i[CountW-1:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tsi_core.sv
// Interlock state and the per-command next-state logic.
// Depends on tsi_pkg; state advances only when the top level moves an item to the result register.
module tsi_core import tsi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic signed [TempW-1:0] temperature_i,
  input  logic                    temp_valid_i,
  input  cfg_t                    cfg_i,
  output result_t                 result_o
);

  mode_e             mode_q, mode_d;
  logic              lock_q, lock_d;
  logic              safe_q, safe_d;
  logic              alert_sent_q, alert_sent_d;
  logic              relay_q, relay_d;
  logic [CountW-1:0] boots_q, boots_d;
  logic              accepted;
  alert_e            alert;
  logic              below_hyst;

  // t < warning - 48, done as t + 48 < warning at one extra bit
  assign below_hyst = (signed'({temperature_i[TempW-1], temperature_i}) + HystSixteenths)
                      < signed'({cfg_i.warning_level[TempW-1], cfg_i.warning_level});

  always_comb begin
    mode_d       = mode_q;
    lock_d       = lock_q;
    safe_d       = safe_q;
    alert_sent_d = alert_sent_q;
    relay_d      = relay_q;
    boots_d      = boots_q;
    accepted     = 1'b0;
    alert        = AlertNone;
    unique case (cmd_e'(cmd_i))
      CmdBoot: begin
        mode_d       = ModeNominal;
        lock_d       = 1'b0;
        alert_sent_d = 1'b0;
        relay_d      = 1'b0;
        safe_d       = (boots_q >= cfg_i.crash_limit);
        if (boots_q != CountMax) begin
          boots_d = boots_q + 1'b1;
        end
        if (boots_q >= cfg_i.crash_limit) begin
          mode_d = ModeLockout;
          lock_d = 1'b1;
        end
      end
      CmdCheck: begin
        if (!safe_q && temp_valid_i) begin
          if (temperature_i >= cfg_i.critical_level) begin
            if (!lock_q) begin
              relay_d = 1'b0;
              mode_d  = ModeLockout;
              lock_d  = 1'b1;
              alert   = AlertCritical;
            end
          end else if (temperature_i >= cfg_i.warning_level) begin
            if (!alert_sent_q) begin
              mode_d       = ModeWarning;
              alert_sent_d = 1'b1;
              alert        = AlertWarning;
            end
          end else begin
            // auto resume leaves the relay as it is
            if (lock_q && temperature_i <= cfg_i.resume_level) begin
              lock_d       = 1'b0;
              mode_d       = ModeNominal;
              alert_sent_d = 1'b0;
              alert        = AlertResumed;
            end
            if (mode_d == ModeWarning && below_hyst) begin
              mode_d       = ModeNominal;
              alert_sent_d = 1'b0;
            end
          end
        end
      end
      CmdArm: begin
        if (mode_q != ModeLockout && !safe_q) begin
          if (temp_valid_i && temperature_i > cfg_i.critical_level) begin
            relay_d = 1'b0;
            mode_d  = ModeLockout;
            lock_d  = 1'b1;
          end else begin
            relay_d  = 1'b1;
            accepted = 1'b1;
          end
        end
      end
      CmdDisarm: begin
        relay_d = 1'b0;
      end
      CmdReset: begin
        if (!(lock_q && temp_valid_i && temperature_i > cfg_i.resume_level)) begin
          mode_d       = ModeNominal;
          lock_d       = 1'b0;
          safe_d       = 1'b0;
          alert_sent_d = 1'b0;
          boots_d      = '0;
          accepted     = 1'b1;
          alert        = AlertReset;
        end
      end
      default: begin
        accepted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeNominal;
      lock_q       <= 1'b0;
      safe_q       <= 1'b0;
      alert_sent_q <= 1'b0;
      relay_q      <= 1'b0;
      boots_q      <= '0;
    end else if (fire_i) begin
      mode_q       <= mode_d;
      lock_q       <= lock_d;
      safe_q       <= safe_d;
      alert_sent_q <= alert_sent_d;
      relay_q      <= relay_d;
      boots_q      <= boots_d;
    end
  end

  assign result_o = '{
    relay_on:       relay_d,
    safety_mode:    mode_d,
    accepted:       accepted,
    alert_code:     alert,
    thermal_locked: lock_d,
    loop_guard:     safe_d,
    boots_seen:     boots_d
  };

endmodule

// File: rtl/thermal_safety_interlock.sv
// Pump relay thermal safety interlock, top level.
// Usage:
//   Commands enter on the input channel (in_valid_i / in_stall_o) with cmd_i,
//   temperature_i (signed, 1/16 degree C) and temp_valid_i. Each command gives
//   exactly one status result on the output channel (out_valid_o / out_stall_i).
//   A transfer happens on a rising edge with valid high and stall low.
//   Levels and crash limit are written through cfg_valid_i / cfg_ready_o with
//   cfg_index_i and cfg_data_i; cfg_ready_o is always high. Write them only
//   while no command is in flight.
// Timing:
//   A command is held in the input register, and its result is registered
//   in the result register that drives out_valid_o. One command per cycle
//   is sustained while the receiver does not stall; the status logic
//   between input and result register is a single pass of compares and
//   flag updates. When the receiver stalls, the result holds; a command is
//   taken only into an empty input register, and then in_stall_o rises.
// Reset:
//   rst_ni clears the valid flags of both registers, all flags, the boot
//   counter and restores the default levels (960, 800, 640) and crash limit 3.
// Depends on tsi_pkg, tsi_cfg_regs and tsi_core.
module thermal_safety_interlock import tsi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic signed [TempW-1:0] temperature_i,
  input  logic                    temp_valid_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    relay_on_o,
  output logic [ModeW-1:0]        safety_mode_o,
  output logic                    accepted_o,
  output logic [AlertW-1:0]       alert_code_o,
  output logic                    thermal_locked_o,
  output logic                    loop_guard_o,
  output logic [CountW-1:0]       boots_seen_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  logic                    in_valid_q;
  logic [CmdW-1:0]         cmd_q;
  logic signed [TempW-1:0] temp_q;
  logic                    temp_valid_q;
  logic                    out_valid_q;
  result_t                 res_q, res_d;
  cfg_t                    cfg;
  logic                    out_ready;
  logic                    fire;
  logic                    in_xfer;

  assign cfg_ready_o = 1'b1;
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && out_ready;
  assign in_stall_o  = in_valid_q && !out_ready;
  assign in_xfer     = in_valid_i && !in_stall_o;

  tsi_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tsi_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .cmd_i         (cmd_q),
    .temperature_i (temp_q),
    .temp_valid_i  (temp_valid_q),
    .cfg_i         (cfg),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= fire;
      end
    end
  end

  // payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q        <= cmd_i;
      temp_q       <= temperature_i;
      temp_valid_q <= temp_valid_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign relay_on_o       = res_q.relay_on;
  assign safety_mode_o    = res_q.safety_mode;
  assign accepted_o       = res_q.accepted;
  assign alert_code_o     = res_q.alert_code;
  assign thermal_locked_o = res_q.thermal_locked;
  assign loop_guard_o     = res_q.loop_guard;
  assign boots_seen_o     = res_q.boots_seen;

endmodule

// File: rtl/tsi_checker.sv
// Port-level checks for the thermal safety interlock, bound to the top level.
// Depends on tsi_pkg.
module tsi_checker import tsi_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    relay_on_o,
  input logic [ModeW-1:0]        safety_mode_o,
  input logic                    accepted_o,
  input logic [AlertW-1:0]       alert_code_o,
  input logic                    thermal_locked_o,
  input logic                    loop_guard_o,
  input logic [CountW-1:0]       boots_seen_o
);

  // a stalled result stays and holds its relay, alert and boot count
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(relay_on_o)
      && $stable(alert_code_o) && $stable(boots_seen_o))
    else $error("stalled result changed");

  // lockout mode always has the relay open
  a_lock_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && safety_mode_o == ModeLockout |-> !relay_on_o)
    else $error("relay closed in lockout");

  // safe mode implies thermal lockout flag
  a_safe_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loop_guard_o |-> thermal_locked_o)
    else $error("safe mode without lockout");

  // reset done leaves mode, lockout, safe flag and boot count clear
  a_reset_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alert_code_o == AlertReset |-> accepted_o && boots_seen_o == '0
      && !thermal_locked_o && !loop_guard_o && safety_mode_o == ModeNominal)
    else $error("reset lockout left state behind");

  // an accepted command is either a reset or an arm that closed the relay
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> alert_code_o == AlertReset || relay_on_o)
    else $error("accepted without effect");

endmodule

bind thermal_safety_interlock tsi_checker u_tsi_checker (.*);

// File: tb/sv/thermal_safety_interlock_tb.sv
// Self-checking testbench for thermal_safety_interlock: directed table, then random phases.
// Predicts untyped rows from its own interlock model; depends on tsi_pkg and the RTL only.
`timescale 1ns / 100ps

module thermal_safety_interlock_tb;
  import tsi_pkg::*;

  localparam logic [CmdW-1:0] CmdUnusedLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedHi = 3'd7;
  localparam int QuietLimit  = 2000;
  localparam int PhaseItems  = 20;
  localparam int StormBoots  = 256;

  typedef struct {
    logic [CmdW-1:0] cmd;
    int              temp;
    logic            tvalid;
    bit              typed;
    result_t         status;
  } step_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [CmdW-1:0]         cmd_i = '0;
  logic signed [TempW-1:0] temperature_i = '0;
  logic                    temp_valid_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    relay_on_o;
  logic [ModeW-1:0]        safety_mode_o;
  logic                    accepted_o;
  logic [AlertW-1:0]       alert_code_o;
  logic                    thermal_locked_o;
  logic                    loop_guard_o;
  logic [CountW-1:0]       boots_seen_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;

  thermal_safety_interlock dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .temperature_i   (temperature_i),
    .temp_valid_i    (temp_valid_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .relay_on_o      (relay_on_o),
    .safety_mode_o   (safety_mode_o),
    .accepted_o      (accepted_o),
    .alert_code_o    (alert_code_o),
    .thermal_locked_o(thermal_locked_o),
    .loop_guard_o    (loop_guard_o),
    .boots_seen_o    (boots_seen_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Interlock model state and levels
  cfg_t              lvl = '{CriticalReset, WarningReset, ResumeReset, CrashReset};
  mode_e             m_mode = ModeNominal;
  logic              m_locked = 1'b0;
  logic              m_safe = 1'b0;
  logic              m_alerted = 1'b0;
  logic              m_relay = 1'b0;
  logic [CountW-1:0] m_boots = '0;
  logic signed [TempW-1:0] m_last_temp = '0;

  result_t status_q[$];
  step_t   plan[$];
  int      burst_left = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      errors = 0;
  int      quiet_cycles = 0;
  int      settings_used = 0;
  int      alerts_seen[8];

  function automatic result_t make_status(logic relay, mode_e mode, logic acc, alert_e alert,
                                          logic locked, logic safe, logic [CountW-1:0] boots);
    result_t s;
    s.relay_on       = relay;
    s.safety_mode    = mode;
    s.accepted       = acc;
    s.alert_code     = alert;
    s.thermal_locked = locked;
    s.loop_guard     = safe;
    s.boots_seen     = boots;
    return s;
  endfunction

  task automatic enter_lockout();
    m_relay  = 1'b0;
    m_mode   = ModeLockout;
    m_locked = 1'b1;
  endtask

  // Advance the interlock model by one command and return the status it reports.
  task automatic predict_status(input logic [CmdW-1:0] cmd, input logic signed [TempW-1:0] temp,
                                input logic tvalid, output result_t res);
    int     t;
    int     crit;
    int     warn;
    int     resume;
    logic   acc;
    alert_e alert;
    t      = temp;
    crit   = $signed(lvl.critical_level);
    warn   = $signed(lvl.warning_level);
    resume = $signed(lvl.resume_level);
    acc    = 1'b0;
    alert  = AlertNone;
    case (cmd)
      CmdBoot: begin
        m_mode      = ModeNominal;
        m_locked    = 1'b0;
        m_safe      = 1'b0;
        m_alerted   = 1'b0;
        m_relay     = 1'b0;
        m_last_temp = '0;
        if (m_boots >= lvl.crash_limit) m_safe = 1'b1;
        if (m_boots != CountMax) m_boots = m_boots + 1'b1;
        if (m_safe) enter_lockout();
      end
      CmdCheck: begin
        if (!m_safe && tvalid) begin
          m_last_temp = temp;
          if (t >= crit) begin
            if (!m_locked) begin
              enter_lockout();
              alert = AlertCritical;
            end
          end else if (t >= warn) begin
            if (!m_alerted) begin
              m_mode    = ModeWarning;
              m_alerted = 1'b1;
              alert     = AlertWarning;
            end
          end else begin
            if (m_locked && t <= resume) begin
              m_locked  = 1'b0;
              m_mode    = ModeNominal;
              m_alerted = 1'b0;
              alert     = AlertResumed;
            end
            // warning clears only below the hysteresis band
            if (m_mode == ModeWarning && t < warn - int'(HystSixteenths)) begin
              m_mode    = ModeNominal;
              m_alerted = 1'b0;
            end
          end
        end
      end
      CmdArm: begin
        if (m_mode != ModeLockout && !m_safe) begin
          if (tvalid && t > crit) begin
            enter_lockout();
          end else begin
            m_relay = 1'b1;
            acc     = 1'b1;
          end
        end
      end
      CmdDisarm: begin
        m_relay = 1'b0;
      end
      CmdReset: begin
        if (!(m_locked && tvalid && t > resume)) begin
          m_mode    = ModeNominal;
          m_locked  = 1'b0;
          m_safe    = 1'b0;
          m_alerted = 1'b0;
          m_boots   = '0;
          acc       = 1'b1;
          alert     = AlertReset;
        end
      end
      default: ;
    endcase
    res = make_status(m_relay, m_mode, acc, alert, m_locked, m_safe, m_boots);
  endtask

  task automatic add_row(input logic [CmdW-1:0] cmd, input int temp, input logic tvalid,
                         input bit typed = 1'b0, input result_t status = '0);
    step_t s;
    s.cmd    = cmd;
    s.temp   = temp;
    s.tvalid = tvalid;
    s.typed  = typed;
    s.status = status;
    plan.push_back(s);
  endtask

  // Issue one command in bursts with random gaps; valid drops only at the start of a gap.
  task automatic send_command(input logic [CmdW-1:0] cmd, input int temp, input logic tvalid,
                              input bit typed = 1'b0, input result_t status = '0);
    result_t predicted;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    temperature_i <= temp[TempW-1:0];
    temp_valid_i  <= tvalid;
    do @(posedge clk_i); while (in_stall_o);
    predict_status(cmd, temp[TempW-1:0], tvalid, predicted);
    status_q.push_back(typed ? status : predicted);
    items_sent++;
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCritical: lvl.critical_level = data;
      RegWarning:  lvl.warning_level  = data;
      RegResume:   lvl.resume_level   = data;
      RegCrash:    lvl.crash_limit    = data[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_levels(input int crit, input int warn, input int resume,
                                input int crash);
    write_register(RegCritical, crit[CfgDataW-1:0]);
    write_register(RegWarning, warn[CfgDataW-1:0]);
    write_register(RegResume, resume[CfgDataW-1:0]);
    write_register(RegCrash, {4'h0, crash[CountW-1:0]});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly land next to a level so every threshold gets crossed from both sides.
  function automatic int choose_temperature();
    int pick;
    int t;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: t = $signed(lvl.critical_level);
        1: t = $signed(lvl.warning_level);
        2: t = $signed(lvl.resume_level);
        default: t = $signed(lvl.warning_level) - int'(HystSixteenths);
      endcase
      t = t + int'($urandom_range(0, 6)) - 3;
      if (t > 2047) t = 2047;
      if (t < -2048) t = -2048;
    end else if (pick < 66) begin
      t = $urandom_range(0, 1) ? 2047 : -2048;
    end else begin
      t = int'($urandom_range(0, 4095)) - 2048;
    end
    return t;
  endfunction

  task automatic send_random_command();
    int              pick;
    logic [CmdW-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 45)      cmd = CmdCheck;
    else if (pick < 62) cmd = CmdArm;
    else if (pick < 72) cmd = CmdDisarm;
    else if (pick < 83) cmd = CmdReset;
    else if (pick < 95) cmd = CmdBoot;
    else                cmd = CmdW'($urandom_range(CmdUnusedLo, CmdUnusedHi));
    send_command(cmd, choose_temperature(), $urandom_range(0, 99) < 85);
  endtask

  // Receiver: stall density is redrawn after a random hold, sometimes none at all.
  int stall_level = 0;
  int stall_hold = 0;
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_level = $urandom_range(0, 3);
      stall_hold  = $urandom_range(8, 80);
    end else begin
      stall_hold--;
    end
    out_stall_i <= ($urandom_range(0, 3) < stall_level);
  end

  always @(posedge clk_i) begin : status_check
    result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $error("status transfer with no command pending");
          errors++;
        end else begin
          want = status_q.pop_front();
          results_checked++;
          alerts_seen[want.alert_code]++;
          if (relay_on_o !== want.relay_on) begin
            $error("relay_on: expected %0d, got %0d", want.relay_on, relay_on_o);
            errors++;
          end
          if (safety_mode_o !== want.safety_mode) begin
            $error("safety_mode: expected %0d, got %0d", want.safety_mode, safety_mode_o);
            errors++;
          end
          if (accepted_o !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, accepted_o);
            errors++;
          end
          if (alert_code_o !== want.alert_code) begin
            $error("alert_code: expected %0d, got %0d", want.alert_code, alert_code_o);
            errors++;
          end
          if (thermal_locked_o !== want.thermal_locked) begin
            $error("thermal_locked: expected %0d, got %0d", want.thermal_locked,
                   thermal_locked_o);
            errors++;
          end
          if (loop_guard_o !== want.loop_guard) begin
            $error("loop_guard: expected %0d, got %0d", want.loop_guard, loop_guard_o);
            errors++;
          end
          if (boots_seen_o !== want.boots_seen) begin
            $error("boots_seen: expected %0d, got %0d", want.boots_seen, boots_seen_o);
            errors++;
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: %0d cycles without a transfer, %0d statuses pending",
                 quiet_cycles, status_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int crit;
    int warn;
    int resume;
    int crash;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with reset levels 960 / 800 / 640, crash limit 3
    add_row(CmdCheck, 0, 1'b0, 1'b1,
            make_status(1'b0, ModeNominal, 1'b0, AlertNone, 1'b0, 1'b0, 8'd0));
    add_row(CmdBoot, 0, 1'b0, 1'b1,
            make_status(1'b0, ModeNominal, 1'b0, AlertNone, 1'b0, 1'b0, 8'd1));
    add_row(CmdArm, 2047, 1'b0, 1'b1,
            make_status(1'b1, ModeNominal, 1'b1, AlertNone, 1'b0, 1'b0, 8'd1));
    add_row(CmdCheck, 800, 1'b1, 1'b1,
            make_status(1'b1, ModeWarning, 1'b0, AlertWarning, 1'b0, 1'b0, 8'd1));
    add_row(CmdCheck, 752, 1'b1);              // inside hysteresis band: hold warning
    add_row(CmdCheck, 751, 1'b1);              // just below band: back to nominal
    add_row(CmdCheck, 960, 1'b1, 1'b1,
            make_status(1'b0, ModeLockout, 1'b0, AlertCritical, 1'b1, 1'b0, 8'd1));
    add_row(CmdArm, 0, 1'b1, 1'b1,
            make_status(1'b0, ModeLockout, 1'b0, AlertNone, 1'b1, 1'b0, 8'd1));
    add_row(CmdCheck, 900, 1'b1);              // warning overrides lockout mode
    add_row(CmdCheck, 641, 1'b1);
    add_row(CmdArm, 2047, 1'b1);               // arm above critical trips lockout
    add_row(CmdReset, 641, 1'b1);              // refused: still above resume
    add_row(CmdCheck, 640, 1'b1);              // auto resume at the level
    add_row(CmdCheck, -2048, 1'b1);
    add_row(CmdBoot, 0, 1'b0);
    add_row(CmdBoot, 0, 1'b0);
    add_row(CmdBoot, 0, 1'b0, 1'b1,
            make_status(1'b0, ModeLockout, 1'b0, AlertNone, 1'b1, 1'b1, 8'd4));
    add_row(CmdCheck, 2047, 1'b1);             // ignored in safe mode
    add_row(CmdArm, 0, 1'b0);
    add_row(CmdReset, 2047, 1'b1);
    add_row(CmdReset, 2047, 1'b0, 1'b1,
            make_status(1'b0, ModeNominal, 1'b1, AlertReset, 1'b0, 1'b0, 8'd0));
    add_row(CmdArm, 960, 1'b1);                // exactly critical still arms
    add_row(CmdUnusedLo, 0, 1'b1);
    add_row(CmdUnusedHi, 2047, 1'b1);
    add_row(CmdDisarm, -1, 1'b1);
    add_row(CmdReset, 2047, 1'b1);
    foreach (plan[i]) send_command(plan[i].cmd, plan[i].temp, plan[i].tvalid,
                                   plan[i].typed, plan[i].status);

    for (int phase = 0; phase < 6; phase++) begin
      wait_for_idle();
      case (phase)
        0: begin crit = 960;   warn = 800;   resume = 640;   crash = 3;   end
        1: begin crit = 2047;  warn = -2048; resume = -2048; crash = 1;   end
        2: begin crit = -2048; warn = -2048; resume = 2047;  crash = 0;   end
        3: begin crit = 2047;  warn = 2047;  resume = -2048; crash = 255; end
        default: begin
          resume = int'($urandom_range(0, 1600)) - 1000;
          warn   = resume + int'($urandom_range(1, 200));
          crit   = warn + int'($urandom_range(1, 200));
          crash  = $urandom_range(1, 6);
        end
      endcase
      program_levels(crit, warn, resume, crash);
      // saturate the boot counter and hit safe mode at the top crash limit
      if (phase == 3) for (int b = 0; b < StormBoots; b++) send_command(CmdBoot, 0, 1'b0);
      repeat (PhaseItems) send_random_command();
    end

    wait_for_idle();
    repeat (4) @(posedge clk_i);
    $display("Ran %0d commands over %0d level settings; %0d statuses compared, %0d errors",
             items_sent, settings_used, results_checked, errors);
    $display("Alerts: critical %0d, warning %0d, resumed %0d, reset %0d",
             alerts_seen[AlertCritical], alerts_seen[AlertWarning],
             alerts_seen[AlertResumed], alerts_seen[AlertReset]);
    if (errors == 0 && status_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: thermal_safety_interlock.f
rtl/tsi_pkg.sv
rtl/tsi_cfg_regs.sv
rtl/tsi_core.sv
rtl/thermal_safety_interlock.sv
rtl/tsi_checker.sv
tb/sv/thermal_safety_interlock_tb.sv
